FILE: sv/strided_access_dependence_test_top_assert.svh
`ifndef STRIDED_ACCESS_DEPENDENCE_TEST_TOP_ASSERT_SVH
`define STRIDED_ACCESS_DEPENDENCE_TEST_TOP_ASSERT_SVH
// ------------------------------------------------------------------------------------------
// Assertion macros for the strided access dependence test
// Same-cycle and next-cycle implication checks, reset disables both.
// ------------------------------------------------------------------------------------------

// consequent holds in the cycle of the antecedent
`define SADT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sadt: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define SADT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sadt: next-cycle check failed");

`endif

FILE: sv/sadt_pkg.sv
// ------------------------------------------------------------------------------------------
// sadt_pkg
// Shared codes, defaults and the control word carried down the divider chain.
// ------------------------------------------------------------------------------------------
package sadt_pkg;

    localparam int DEF_ADDR_BITS = 32;
    localparam int DEF_SIZE_BITS = 8;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;
    localparam logic [1:0] KIND_WAR  = 2'd2;
    localparam logic [1:0] KIND_WAW  = 2'd3;

    localparam logic [1:0] DIR_ANY = 2'd0;
    localparam logic [1:0] DIR_EQ  = 2'd1;
    localparam logic [1:0] DIR_FWD = 2'd2;
    localparam logic [1:0] DIR_BWD = 2'd3;

    // result class decided before the divide
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_UNK  = 2'd1;
    localparam logic [1:0] CLS_DIV  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] cls;
        logic       q_neg;
        logic       d_neg;
    } t_ctl;

endpackage

FILE: sv/sadt_if.sv
// ------------------------------------------------------------------------------------------
// sadt_in_if / sadt_out_if
// Valid/ready channels for the access pair item and the dependence result item.
// ------------------------------------------------------------------------------------------
interface sadt_in_if import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic                 first_is_store;
    logic                 second_is_store;
    logic                 first_valid;
    logic                 second_valid;
    logic                 same_base;
    logic                 proven_no_alias;
    logic [ADDR_BITS-1:0] first_stride;
    logic [ADDR_BITS-1:0] second_stride;
    logic [ADDR_BITS-1:0] first_offset;
    logic [ADDR_BITS-1:0] second_offset;
    logic [SIZE_BITS-1:0] first_size;
    logic [SIZE_BITS-1:0] second_size;

    modport source (
        output valid, first_is_store, second_is_store, first_valid, second_valid,
               same_base, proven_no_alias, first_stride, second_stride,
               first_offset, second_offset, first_size, second_size,
        input  ready
    );
    modport sink (
        input  valid, first_is_store, second_is_store, first_valid, second_valid,
               same_base, proven_no_alias, first_stride, second_stride,
               first_offset, second_offset, first_size, second_size,
        output ready
    );
endinterface

interface sadt_out_if import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) ();
    logic               valid;
    logic               ready;
    logic [1:0]         dep_kind;
    logic [1:0]         direction;
    logic               loop_carried;
    logic               dist_exact;
    logic [ADDR_BITS:0] distance;

    modport source (
        output valid, dep_kind, direction, loop_carried, dist_exact, distance,
        input  ready
    );
    modport sink (
        input  valid, dep_kind, direction, loop_carried, dist_exact, distance,
        output ready
    );
endinterface

FILE: sv/sadt_prep.sv
// ------------------------------------------------------------------------------------------
// sadt_prep
// Two front stages: classify the pair, form offset difference and stride magnitude,
// then take the magnitude of the difference as the dividend.
// ------------------------------------------------------------------------------------------
module sadt_prep import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic                 i_first_is_store,
    input  logic                 i_second_is_store,
    input  logic                 i_first_valid,
    input  logic                 i_second_valid,
    input  logic                 i_same_base,
    input  logic                 i_proven_no_alias,
    input  logic [ADDR_BITS-1:0] i_first_stride,
    input  logic [ADDR_BITS-1:0] i_second_stride,
    input  logic [ADDR_BITS-1:0] i_first_offset,
    input  logic [ADDR_BITS-1:0] i_second_offset,
    input  logic [SIZE_BITS-1:0] i_first_size,
    input  logic [SIZE_BITS-1:0] i_second_size,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output t_ctl                 o_ctl,
    output logic [SIZE_BITS-1:0] o_z1,
    output logic [SIZE_BITS-1:0] o_z2,
    output logic [ADDR_BITS-1:0] o_div,
    output logic [ADDR_BITS-1:0] o_dq
);

    logic                 r_a_vld;
    t_ctl                 r_a_ctl;
    logic [ADDR_BITS:0]   r_a_diff;
    logic [ADDR_BITS-1:0] r_a_div;
    logic [SIZE_BITS-1:0] r_a_z1;
    logic [SIZE_BITS-1:0] r_a_z2;

    logic                 r_b_vld;
    t_ctl                 r_b_ctl;
    logic [ADDR_BITS-1:0] r_b_dq;
    logic [ADDR_BITS-1:0] r_b_div;
    logic [SIZE_BITS-1:0] r_b_z1;
    logic [SIZE_BITS-1:0] r_b_z2;

    t_ctl                 n_a_ctl;
    logic [ADDR_BITS:0]   n_a_diff;
    logic [ADDR_BITS-1:0] n_a_div;
    t_ctl                 n_b_ctl;
    logic [ADDR_BITS:0]   w_diff_neg;
    logic [ADDR_BITS-1:0] n_b_dq;
    logic                 w_a_rdy;
    logic                 w_b_rdy;

    assign w_b_rdy = !r_b_vld || i_rdy;
    assign w_a_rdy = !r_a_vld || w_b_rdy;
    assign o_rdy   = w_a_rdy;

    always_comb begin
        n_a_ctl       = '0;
        n_a_ctl.kind  = KIND_NONE;
        n_a_ctl.cls   = CLS_NONE;
        n_a_ctl.q_neg = i_first_stride[ADDR_BITS-1];
        if (i_first_is_store || i_second_is_store) begin
            if (i_first_is_store && !i_second_is_store) begin
                n_a_ctl.kind = KIND_RAW;
            end else if (!i_first_is_store && i_second_is_store) begin
                n_a_ctl.kind = KIND_WAR;
            end else begin
                n_a_ctl.kind = KIND_WAW;
            end
            if (!i_first_valid || !i_second_valid) begin
                n_a_ctl.cls = CLS_UNK;
            end else if (!i_same_base) begin
                if (i_proven_no_alias) begin
                    n_a_ctl.kind = KIND_NONE;
                    n_a_ctl.cls  = CLS_NONE;
                end else begin
                    n_a_ctl.cls = CLS_UNK;
                end
            end else if ((i_first_stride != i_second_stride) || (i_first_stride == '0)) begin
                n_a_ctl.cls = CLS_UNK;
            end else begin
                n_a_ctl.cls = CLS_DIV;
            end
        end
    end

    assign n_a_diff = {i_second_offset[ADDR_BITS-1], i_second_offset}
                    - {i_first_offset[ADDR_BITS-1], i_first_offset};
    assign n_a_div  = i_first_stride[ADDR_BITS-1] ? ('0 - i_first_stride) : i_first_stride;

    // stage B: dividend magnitude and quotient sign
    assign w_diff_neg = '0 - r_a_diff;
    assign n_b_dq     = r_a_diff[ADDR_BITS] ? w_diff_neg[ADDR_BITS-1:0] : r_a_diff[ADDR_BITS-1:0];

    always_comb begin
        n_b_ctl       = r_a_ctl;
        n_b_ctl.d_neg = r_a_diff[ADDR_BITS];
        n_b_ctl.q_neg = r_a_diff[ADDR_BITS] ^ r_a_ctl.q_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (w_a_rdy) begin
                r_a_vld <= i_vld;
            end
            if (w_b_rdy) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy && i_vld) begin
            r_a_ctl  <= n_a_ctl;
            r_a_diff <= n_a_diff;
            r_a_div  <= n_a_div;
            r_a_z1   <= i_first_size;
            r_a_z2   <= i_second_size;
        end
        if (w_b_rdy && r_a_vld) begin
            r_b_ctl <= n_b_ctl;
            r_b_dq  <= n_b_dq;
            r_b_div <= r_a_div;
            r_b_z1  <= r_a_z1;
            r_b_z2  <= r_a_z2;
        end
    end

    assign o_vld = r_b_vld;
    assign o_ctl = r_b_ctl;
    assign o_z1  = r_b_z1;
    assign o_z2  = r_b_z2;
    assign o_div = r_b_div;
    assign o_dq  = r_b_dq;

endmodule

FILE: sv/sadt_cell.sv
// ------------------------------------------------------------------------------------------
// sadt_cell
// One restoring division step: shifts in a dividend bit, trial-subtracts the divisor
// and shifts the quotient bit into the low end of the dividend word.
// ------------------------------------------------------------------------------------------
module sadt_cell import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  t_ctl                 i_ctl,
    input  logic [SIZE_BITS-1:0] i_z1,
    input  logic [SIZE_BITS-1:0] i_z2,
    input  logic [ADDR_BITS-1:0] i_div,
    input  logic [ADDR_BITS-1:0] i_rem,
    input  logic [ADDR_BITS-1:0] i_dq,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output t_ctl                 o_ctl,
    output logic [SIZE_BITS-1:0] o_z1,
    output logic [SIZE_BITS-1:0] o_z2,
    output logic [ADDR_BITS-1:0] o_div,
    output logic [ADDR_BITS-1:0] o_rem,
    output logic [ADDR_BITS-1:0] o_dq
);

    logic                 r_vld;
    t_ctl                 r_ctl;
    logic [SIZE_BITS-1:0] r_z1;
    logic [SIZE_BITS-1:0] r_z2;
    logic [ADDR_BITS-1:0] r_div;
    logic [ADDR_BITS-1:0] r_rem;
    logic [ADDR_BITS-1:0] r_dq;

    logic [ADDR_BITS:0]   w_trial;
    logic [ADDR_BITS:0]   w_sub;
    logic                 w_ge;
    logic [ADDR_BITS-1:0] n_rem;
    logic [ADDR_BITS-1:0] n_dq;
    logic                 w_rdy;

    assign w_rdy = !r_vld || i_rdy;
    assign o_rdy = w_rdy;

    assign w_trial = {i_rem, i_dq[ADDR_BITS-1]};
    assign w_sub   = w_trial - {1'b0, i_div};
    assign w_ge    = w_trial >= {1'b0, i_div};
    assign n_rem   = w_ge ? w_sub[ADDR_BITS-1:0] : w_trial[ADDR_BITS-1:0];
    assign n_dq    = {i_dq[ADDR_BITS-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_vld) begin
            r_ctl <= i_ctl;
            r_z1  <= i_z1;
            r_z2  <= i_z2;
            r_div <= i_div;
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_z1  = r_z1;
    assign o_z2  = r_z2;
    assign o_div = r_div;
    assign o_rem = r_rem;
    assign o_dq  = r_dq;

endmodule

FILE: sv/sadt_fin.sv
// ------------------------------------------------------------------------------------------
// sadt_fin
// Output register: signed distance and direction for an exact quotient, otherwise the
// gap test within one stride period, folded into the result item.
// ------------------------------------------------------------------------------------------
module sadt_fin import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  t_ctl                 i_ctl,
    input  logic [SIZE_BITS-1:0] i_z1,
    input  logic [SIZE_BITS-1:0] i_z2,
    input  logic [ADDR_BITS-1:0] i_div,
    input  logic [ADDR_BITS-1:0] i_rem,
    input  logic [ADDR_BITS-1:0] i_dq,
    output logic                 o_vld,
    input  logic                 i_rdy,
    output logic [1:0]           o_dep_kind,
    output logic [1:0]           o_direction,
    output logic                 o_loop_carried,
    output logic                 o_dist_exact,
    output logic [ADDR_BITS:0]   o_distance
);

    localparam int CW = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 1;

    logic               r_vld;
    logic [1:0]         r_kind;
    logic [1:0]         r_dir;
    logic               r_carried;
    logic               r_hasd;
    logic [ADDR_BITS:0] r_dist;

    logic [1:0]         n_kind;
    logic [1:0]         n_dir;
    logic               n_carried;
    logic               n_hasd;
    logic [ADDR_BITS:0] n_dist;

    logic [CW-1:0]      w_rem;
    logic [CW-1:0]      w_per;
    logic [CW-1:0]      w_z1;
    logic [CW-1:0]      w_z2;
    logic               w_fit;
    logic [ADDR_BITS:0] w_q;
    logic               w_rdy;

    assign w_rdy = !r_vld || i_rdy;
    assign o_rdy = w_rdy;

    assign w_rem = {{(CW-ADDR_BITS){1'b0}}, i_rem};
    assign w_per = {{(CW-ADDR_BITS){1'b0}}, i_div};
    assign w_z1  = {{(CW-SIZE_BITS){1'b0}}, i_z1};
    assign w_z2  = {{(CW-SIZE_BITS){1'b0}}, i_z2};
    assign w_q   = {1'b0, i_dq};

    // negative difference: true residue is period minus remainder magnitude
    always_comb begin
        if (i_ctl.d_neg) begin
            w_fit = (w_z2 <= w_rem) && ((w_rem + w_z1) <= w_per);
        end else begin
            w_fit = (w_rem >= w_z1) && ((w_rem + w_z2) <= w_per);
        end
        w_fit = w_fit && (i_z1 != '0) && (i_z2 != '0);
    end

    always_comb begin
        n_kind    = i_ctl.kind;
        n_dir     = DIR_ANY;
        n_carried = 1'b1;
        n_hasd    = 1'b0;
        n_dist    = '0;
        case (i_ctl.cls)
            CLS_NONE: begin
                n_kind    = KIND_NONE;
                n_carried = 1'b0;
            end
            CLS_DIV: begin
                if (i_rem == '0) begin
                    n_hasd    = 1'b1;
                    n_dist    = i_ctl.q_neg ? ('0 - w_q) : w_q;
                    n_carried = (i_dq != '0);
                    if (i_dq == '0) begin
                        n_dir = DIR_EQ;
                    end else if (i_ctl.q_neg) begin
                        n_dir = DIR_BWD;
                    end else begin
                        n_dir = DIR_FWD;
                    end
                end else if (w_fit) begin
                    n_kind    = KIND_NONE;
                    n_carried = 1'b0;
                end
            end
            default: begin
                n_carried = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_vld) begin
            r_kind    <= n_kind;
            r_dir     <= n_dir;
            r_carried <= n_carried;
            r_hasd    <= n_hasd;
            r_dist    <= n_dist;
        end
    end

    assign o_vld          = r_vld;
    assign o_dep_kind     = r_kind;
    assign o_direction    = r_dir;
    assign o_loop_carried = r_carried;
    assign o_dist_exact   = r_hasd;
    assign o_distance     = r_dist;

endmodule

FILE: sv/strided_access_dependence_test_top.sv
// ------------------------------------------------------------------------------------------
// strided_access_dependence_test_top
// Strong SIV dependence test on two strided accesses, pipelined divider chain.
//
//   channel  dir  handshake        payload
//   i_in     in   valid / ready    access pair: flags, strides, offsets, sizes
//   o_out    out  valid / ready    dep_kind, direction, loop_carried, dist_exact, distance
//
// One item per cycle while o_out.ready is not held low; the pipeline is the chain of
// one-bit restoring division cells, two front stages and the output register.
// Reset clears the valid bit of every stage; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled; i_in.ready drops only
// once every stage is full.
// ------------------------------------------------------------------------------------------
module strided_access_dependence_test_top import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sadt_in_if.sink     i_in,
    sadt_out_if.source  o_out
);

    localparam int N = ADDR_BITS;

    logic [N:0]           w_vld;
    logic [N:0]           w_rdy;
    t_ctl                 w_ctl [N+1];
    logic [SIZE_BITS-1:0] w_z1  [N+1];
    logic [SIZE_BITS-1:0] w_z2  [N+1];
    logic [ADDR_BITS-1:0] w_div [N+1];
    logic [ADDR_BITS-1:0] w_rem [N+1];
    logic [ADDR_BITS-1:0] w_dq  [N+1];

    assign w_rem[0] = '0;

    sadt_prep #(
        .ADDR_BITS (ADDR_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_prep (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_vld             (i_in.valid),
        .o_rdy             (i_in.ready),
        .i_first_is_store  (i_in.first_is_store),
        .i_second_is_store (i_in.second_is_store),
        .i_first_valid     (i_in.first_valid),
        .i_second_valid    (i_in.second_valid),
        .i_same_base       (i_in.same_base),
        .i_proven_no_alias (i_in.proven_no_alias),
        .i_first_stride    (i_in.first_stride),
        .i_second_stride   (i_in.second_stride),
        .i_first_offset    (i_in.first_offset),
        .i_second_offset   (i_in.second_offset),
        .i_first_size      (i_in.first_size),
        .i_second_size     (i_in.second_size),
        .o_vld             (w_vld[0]),
        .i_rdy             (w_rdy[0]),
        .o_ctl             (w_ctl[0]),
        .o_z1              (w_z1[0]),
        .o_z2              (w_z2[0]),
        .o_div             (w_div[0]),
        .o_dq              (w_dq[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        sadt_cell #(
            .ADDR_BITS (ADDR_BITS),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_ctl   (w_ctl[g]),
            .i_z1    (w_z1[g]),
            .i_z2    (w_z2[g]),
            .i_div   (w_div[g]),
            .i_rem   (w_rem[g]),
            .i_dq    (w_dq[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_ctl   (w_ctl[g+1]),
            .o_z1    (w_z1[g+1]),
            .o_z2    (w_z2[g+1]),
            .o_div   (w_div[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_dq    (w_dq[g+1])
        );
    end

    sadt_fin #(
        .ADDR_BITS (ADDR_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_fin (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (w_vld[N]),
        .o_rdy          (w_rdy[N]),
        .i_ctl          (w_ctl[N]),
        .i_z1           (w_z1[N]),
        .i_z2           (w_z2[N]),
        .i_div          (w_div[N]),
        .i_rem          (w_rem[N]),
        .i_dq           (w_dq[N]),
        .o_vld          (o_out.valid),
        .i_rdy          (o_out.ready),
        .o_dep_kind     (o_out.dep_kind),
        .o_direction    (o_out.direction),
        .o_loop_carried (o_out.loop_carried),
        .o_dist_exact   (o_out.dist_exact),
        .o_distance     (o_out.distance)
    );

endmodule

FILE: sv/sadt_checker.sv
// ------------------------------------------------------------------------------------------
// sadt_checker
// Port-level checks on the result channel, bound to the top level.
// ------------------------------------------------------------------------------------------
`include "strided_access_dependence_test_top_assert.svh"

module sadt_checker import sadt_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [1:0]         i_dep_kind,
    input logic [1:0]         i_direction,
    input logic               i_loop_carried,
    input logic               i_dist_exact,
    input logic [ADDR_BITS:0] i_distance
);

    logic                 w_stall;
    logic                 w_exact;
    logic                 w_none;
    logic                 w_known;
    logic                 w_clean;
    logic [ADDR_BITS+6:0] w_payload;

    assign w_stall   = i_out_valid && !i_out_ready;
    assign w_exact   = i_out_valid && i_dist_exact;
    assign w_none    = i_out_valid && (i_dep_kind == KIND_NONE);
    assign w_known   = (i_dep_kind != KIND_NONE) && (i_direction != DIR_ANY);
    assign w_clean   = !i_loop_carried && !i_dist_exact && (i_direction == DIR_ANY)
                     && (i_distance == '0);
    assign w_payload = {i_dep_kind, i_direction, i_loop_carried, i_dist_exact, i_distance};

    // stalled item holds
    `SADT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(w_payload))

    `SADT_ASSERT_IMP(a_dist_known, i_clk, i_rst_n, w_exact, w_known)

    `SADT_ASSERT_IMP(a_none_clean, i_clk, i_rst_n, w_none, w_clean)

    `SADT_ASSERT_IMP(a_carried_dir, i_clk, i_rst_n, w_exact, i_loop_carried == (i_direction != DIR_EQ))

endmodule

bind strided_access_dependence_test_top sadt_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_sadt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_dep_kind     (o_out.dep_kind),
    .i_direction    (o_out.direction),
    .i_loop_carried (o_out.loop_carried),
    .i_dist_exact   (o_out.dist_exact),
    .i_distance     (o_out.distance)
);

FILE: sim/tb_top.sv
// ------------------------------------------------------------------------------------------
// tb_top
// Testbench for the strided access dependence test. A directed table of access pairs
// (both loads, invalid accesses, base flags, stride mismatches, exact distances at the
// extremes, gap fits and misses) is followed by random pairs, mostly well-formed strong
// SIV queries with a share of broken and fully random ones. Each accepted item gets an
// expected result from the table or an in-bench predictor, and every result item is
// checked in order. Both sides idle in random bursts; the receiver once holds off long
// enough to fill the divider chain.
// ------------------------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sadt_pkg::*;

    localparam int AW        = DEF_ADDR_BITS;
    localparam int SW        = DEF_SIZE_BITS;
    localparam int PIPE_LAT  = AW + 3;
    localparam int N_RANDOM  = 400;
    localparam int HOLD_LEN  = 150;
    localparam int LIMIT     = 60000;

    typedef struct packed {
        logic          first_is_store;
        logic          second_is_store;
        logic          first_valid;
        logic          second_valid;
        logic          same_base;
        logic          proven_no_alias;
        logic [AW-1:0] first_stride;
        logic [AW-1:0] second_stride;
        logic [AW-1:0] first_offset;
        logic [AW-1:0] second_offset;
        logic [SW-1:0] first_size;
        logic [SW-1:0] second_size;
    } t_pair;

    typedef struct packed {
        logic [1:0]  dep_kind;
        logic [1:0]  direction;
        logic        loop_carried;
        logic        dist_exact;
        logic [AW:0] distance;
    } t_dep;

    typedef struct {
        t_pair pair;
        bit    fixed;
        t_dep  want;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sadt_in_if  #(.ADDR_BITS(AW), .SIZE_BITS(SW)) in_if ();
    sadt_out_if #(.ADDR_BITS(AW))                 out_if ();

    strided_access_dependence_test_top #(.ADDR_BITS(AW), .SIZE_BITS(SW)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_dep dep_q[$];
    t_row rows[$];
    int   fail_cnt = 0;
    int   cycle_cnt = 0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   stall_left = 0;
    t_dep got_dep;
    t_dep want_dep;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic t_dep classify_pair(input t_pair p);
        t_dep   res;
        longint s1, s2, o1, o2, z1, z2, diff, q, per, rem;
        bit     unk;
        res = '0;
        unk = 1'b0;
        s1 = longint'($signed(p.first_stride));
        s2 = longint'($signed(p.second_stride));
        o1 = longint'($signed(p.first_offset));
        o2 = longint'($signed(p.second_offset));
        z1 = longint'(p.first_size);
        z2 = longint'(p.second_size);
        if (!p.first_is_store && !p.second_is_store) begin
            res.dep_kind = KIND_NONE;
        end else begin
            if (p.first_is_store && !p.second_is_store) res.dep_kind = KIND_RAW;
            else if (!p.first_is_store)                 res.dep_kind = KIND_WAR;
            else                                        res.dep_kind = KIND_WAW;
            if (!p.first_valid || !p.second_valid) begin
                unk = 1'b1;
            end else if (!p.same_base) begin
                if (p.proven_no_alias) res.dep_kind = KIND_NONE;
                else                   unk = 1'b1;
            end else if (s1 != s2 || s1 == 0) begin
                unk = 1'b1;
            end else begin
                diff = o2 - o1;
                if (diff % s1 == 0) begin
                    q = diff / s1;
                    res.dist_exact   = 1'b1;
                    res.distance     = q[AW:0];
                    res.loop_carried = (q != 0);
                    res.direction    = (q == 0) ? DIR_EQ : ((q > 0) ? DIR_FWD : DIR_BWD);
                end else begin
                    per = (s1 < 0) ? -s1 : s1;
                    rem = diff % per;
                    if (rem < 0) rem += per;
                    if (z1 > 0 && z2 > 0 && rem >= z1 && rem + z2 <= per)
                        res.dep_kind = KIND_NONE;
                    else
                        unk = 1'b1;
                end
            end
        end
        if (unk) begin
            res.direction    = DIR_ANY;
            res.loop_carried = 1'b1;
            res.dist_exact   = 1'b0;
            res.distance     = '0;
        end
        return res;
    endfunction

    function automatic t_pair mk_pair(input logic st1, input logic st2, input logic ok1,
                                      input logic ok2, input logic same, input logic na,
                                      input logic [AW-1:0] s1, input logic [AW-1:0] s2,
                                      input logic [AW-1:0] o1, input logic [AW-1:0] o2,
                                      input logic [SW-1:0] z1, input logic [SW-1:0] z2);
        t_pair p;
        p.first_is_store  = st1;
        p.second_is_store = st2;
        p.first_valid     = ok1;
        p.second_valid    = ok2;
        p.same_base       = same;
        p.proven_no_alias = na;
        p.first_stride    = s1;
        p.second_stride   = s2;
        p.first_offset    = o1;
        p.second_offset   = o2;
        p.first_size      = z1;
        p.second_size     = z2;
        return p;
    endfunction

    function automatic t_pair rand_pair();
        t_pair       p;
        logic [31:0] s, k, r;
        longint      mag;
        p.first_is_store  = 1'($urandom_range(0, 1));
        p.second_is_store = 1'($urandom_range(0, 1));
        p.first_valid     = 1'($urandom_range(0, 1));
        p.second_valid    = 1'($urandom_range(0, 1));
        p.same_base       = 1'($urandom_range(0, 1));
        p.proven_no_alias = 1'($urandom_range(0, 1));
        p.first_stride    = $urandom;
        p.second_stride   = $urandom;
        p.first_offset    = $urandom;
        p.second_offset   = $urandom;
        p.first_size      = SW'($urandom);
        p.second_size     = SW'($urandom);
        if ($urandom_range(0, 99) >= 15) begin
            case ($urandom_range(0, 2))
                0:       {p.first_is_store, p.second_is_store} = 2'b10;
                1:       {p.first_is_store, p.second_is_store} = 2'b01;
                default: {p.first_is_store, p.second_is_store} = 2'b11;
            endcase
            p.first_valid  = 1'b1;
            p.second_valid = 1'b1;
            p.same_base    = 1'b1;
            case ($urandom_range(0, 3))
                0:       s = $urandom_range(1, 64);
                1:       s = 32'd1 << $urandom_range(0, 30);
                2:       s = $urandom_range(1, 4096);
                default: s = $urandom;
            endcase
            if (s == 0) s = 32'd1;
            if ($urandom_range(0, 1)) s = -s;
            p.first_stride  = s;
            p.second_stride = s;
            p.first_offset  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1024);
            k   = $urandom_range(0, 16) - 8;
            mag = longint'($signed(s));
            if (mag < 0) mag = -mag;
            r = '0;
            if ($urandom_range(0, 1) && mag > 1) r = $urandom_range(1, 32'(mag - 1));
            p.second_offset = p.first_offset + k * s + r;
            if ($urandom_range(0, 9) == 0) begin
                p.first_size  = SW'($urandom);
                p.second_size = SW'($urandom);
            end else begin
                p.first_size  = SW'($urandom_range(1, 16));
                p.second_size = SW'($urandom_range(1, 16));
            end
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0:       p.first_valid = 1'b0;
                    1:       p.second_valid = 1'b0;
                    2:       p.same_base = 1'b0;
                    default: p.second_stride ^= 32'd1 << $urandom_range(0, 31);
                endcase
            end
        end
        return p;
    endfunction

    task automatic offer_pair(input t_pair p, input t_dep want);
        @(negedge clk);
        in_if.valid           <= 1'b1;
        in_if.first_is_store  <= p.first_is_store;
        in_if.second_is_store <= p.second_is_store;
        in_if.first_valid     <= p.first_valid;
        in_if.second_valid    <= p.second_valid;
        in_if.same_base       <= p.same_base;
        in_if.proven_no_alias <= p.proven_no_alias;
        in_if.first_stride    <= p.first_stride;
        in_if.second_stride   <= p.second_stride;
        in_if.first_offset    <= p.first_offset;
        in_if.second_offset   <= p.second_offset;
        in_if.first_size      <= p.first_size;
        in_if.second_size     <= p.second_size;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        dep_q.push_back(want);
    endtask

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge clk);
            in_if.valid <= 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what, input t_dep want, input t_dep got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $write("%s: expected kind %0d dir %0d carried %0b exact %0b dist %h, ", what,
                   want.dep_kind, want.direction, want.loop_carried, want.dist_exact,
                   want.distance);
            $display("got kind %0d dir %0d carried %0b exact %0b dist %h", got.dep_kind,
                     got.direction, got.loop_carried, got.dist_exact, got.distance);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got_dep = '{out_if.dep_kind, out_if.direction, out_if.loop_carried,
                        out_if.dist_exact, out_if.distance};
            if (dep_q.size() == 0) begin
                note_mismatch("unexpected item", '0, got_dep);
            end else begin
                want_dep = dep_q.pop_front();
                if (got_dep !== want_dep) note_mismatch("mismatch", want_dep, got_dep);
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        in_if.valid           <= 1'b0;
        in_if.first_is_store  <= 1'b0;
        in_if.second_is_store <= 1'b0;
        in_if.first_valid     <= 1'b0;
        in_if.second_valid    <= 1'b0;
        in_if.same_base       <= 1'b0;
        in_if.proven_no_alias <= 1'b0;
        in_if.first_stride    <= '0;
        in_if.second_stride   <= '0;
        in_if.first_offset    <= '0;
        in_if.second_offset   <= '0;
        in_if.first_size      <= '0;
        in_if.second_size     <= '0;

        // st1 st2 ok1 ok2 same na | s1 s2 o1 o2 z1 z2 | fixed | expected
        rows.push_back('{mk_pair(0, 0, 1, 1, 1, 0, 4, 4, 0, 8, 4, 4), 1,
                         '{KIND_NONE, DIR_ANY, 1'b0, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 0, 0, 1, 1, 0, 4, 4, 0, 8, 4, 4), 1,
                         '{KIND_RAW, DIR_ANY, 1'b1, 1'b0, '0}});
        rows.push_back('{mk_pair(0, 1, 1, 0, 1, 0, 4, 4, 0, 8, 4, 4), 1,
                         '{KIND_WAR, DIR_ANY, 1'b1, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 1, 1, 1, 0, 1, 4, 4, 0, 8, 4, 4), 1,
                         '{KIND_NONE, DIR_ANY, 1'b0, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 1, 1, 1, 0, 0, 4, 4, 0, 8, 4, 4), 1,
                         '{KIND_WAW, DIR_ANY, 1'b1, 1'b0, '0}});
        // same base overrides the no-alias flag
        rows.push_back('{mk_pair(1, 0, 1, 1, 1, 1, 4, 4, 0, 8, 4, 4), 1,
                         '{KIND_RAW, DIR_FWD, 1'b1, 1'b1, 33'd2}});
        rows.push_back('{mk_pair(0, 1, 1, 1, 1, 0, 4, 8, 0, 8, 4, 4), 1,
                         '{KIND_WAR, DIR_ANY, 1'b1, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 0, 0, 0, 8, 4, 4), 1,
                         '{KIND_WAW, DIR_ANY, 1'b1, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 0, 1, 1, 1, 0, 8, 8, 16, 16, 4, 4), 1,
                         '{KIND_RAW, DIR_EQ, 1'b0, 1'b1, '0}});
        rows.push_back('{mk_pair(1, 0, 1, 1, 1, 0, 8, 8, 16, -8, 4, 4), 0, '0});
        rows.push_back('{mk_pair(0, 1, 1, 1, 1, 0, -4, -4, 0, 12, 4, 4), 0, '0});
        rows.push_back('{mk_pair(1, 0, 1, 1, 1, 0, 1, 1, 32'h8000_0000, 32'h7fff_ffff,
                                 1, 1), 1,
                         '{KIND_RAW, DIR_FWD, 1'b1, 1'b1, 33'h0_ffff_ffff}});
        rows.push_back('{mk_pair(1, 0, 1, 1, 1, 0, 1, 1, 32'h7fff_ffff, 32'h8000_0000,
                                 1, 1), 1,
                         '{KIND_RAW, DIR_BWD, 1'b1, 1'b1, 33'h1_0000_0001}});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h7fff_ffff, 8'hff, 8'hff), 0, '0});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 0, 1, 1), 0, '0});
        rows.push_back('{mk_pair(0, 1, 1, 1, 1, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                                 0, 32'h7fff_ffff, 4, 4), 0, '0});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, -1, -1, 0, 5, 1, 1), 0, '0});
        // gap fit, overlap, zero sizes
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 16, 16, 0, 8, 4, 4), 1,
                         '{KIND_NONE, DIR_ANY, 1'b0, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 16, 16, 0, 8, 10, 4), 1,
                         '{KIND_WAW, DIR_ANY, 1'b1, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 16, 16, 0, 8, 0, 4), 1,
                         '{KIND_WAW, DIR_ANY, 1'b1, 1'b0, '0}});
        rows.push_back('{mk_pair(1, 0, 1, 1, 1, 0, 16, 16, 0, 8, 4, 0), 0, '0});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 0, 16, 16, 8, 4, 4, 4), 0, '0});
        rows.push_back('{mk_pair(0, 1, 1, 1, 1, 0, -16, -16, 0, 6, 2, 2), 0, '0});
        rows.push_back('{mk_pair(1, 1, 1, 1, 1, 1, -1, -1, -1, -1, 8'hff, 8'hff), 0, '0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 8));
            offer_pair(rows[i].pair, rows[i].fixed ? rows[i].want
                                                   : classify_pair(rows[i].pair));
        end
        idle_for(1);
        while (dep_q.size() != 0) @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            t_pair p;
            if (n == 40) hold_req = 1'b1;
            if (n == N_RANDOM - 60) quiet = 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 8));
            p = rand_pair();
            offer_pair(p, classify_pair(p));
        end
        idle_for(1);

        while (dep_q.size() != 0) @(posedge clk);
        repeat (2 * PIPE_LAT) @(posedge clk);

        if (fail_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/sadt_pkg.sv
sv/sadt_if.sv
sv/sadt_prep.sv
sv/sadt_cell.sv
sv/sadt_fin.sv
sv/strided_access_dependence_test_top.sv
sv/sadt_checker.sv
sim/tb_top.sv
